[sv/ctrq_pkg.sv]
// Package for the coalescing reply queue: sizes, codes and transaction types.
// No dependencies; used by every module of the block.
`default_nettype none
package ctrq_pkg;
  localparam int CAPACITY = 16;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = 5;

  localparam logic [1:0] FUNC_ENQ = 2'd0;
  localparam logic [1:0] FUNC_EXPIRE = 2'd1;
  localparam logic [1:0] FUNC_TAKE = 2'd2;
  localparam logic [1:0] FUNC_NOP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_TIME = 2'd1;
  localparam logic [1:0] ST_FULL_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] now_ms;
    logic [47:0] target;
    logic [15:0] request_code;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             coalesced;
    logic [CNT_W-1:0] purged;
    logic [47:0]      taken_target;
    logic [15:0]      taken_request;
    logic [31:0]      taken_payload;
    logic [63:0]      taken_expiry;
    logic [31:0]      taken_repeats;
    logic [CNT_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic [47:0] target;
    logic [15:0] request;
    logic [31:0] payload;
    logic [63:0] expiry;
    logic [31:0] repeats;
  } slot_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    slot_t            wdata;
    logic [IDX_W-1:0] raddr;
  } ram_ctl_t;
endpackage
`default_nettype wire

[sv/ctrq_slot_ram.sv]
// Slot memory of the reply queue: one write and one registered read per cycle.
// Depends on ctrq_pkg.
`default_nettype none
module ctrq_slot_ram
  import ctrq_pkg::*;
(
  input  wire logic     clk,
  input  wire ram_ctl_t ctl,
  output slot_t         rdata
);
  slot_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    rdata <= mem[ctl.raddr];
  end
endmodule
`default_nettype wire

[sv/coalescing_ttl_reply_queue.sv]
// Top level of the coalescing reply queue with expiry.
// Depends on ctrq_pkg and ctrq_slot_ram.
//
//  channel  | signals                      | transaction when
//  ---------+------------------------------+-----------------------
//  command  | start, busy, req             | start && !busy
//  result   | done, rsp                    | done (one cycle)
//  config   | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
//
// An operation that sweeps reads one slot from the slot memory each cycle and
// writes its survivor back compacted. A rejected time or the unused selector
// skips the sweep and passes through the short state instead.
// Reset clears fill level, last time and ttl (to 1000); slots stay undefined.
// The result cannot be stalled; a new command may arrive with done.
`default_nettype none
module coalescing_ttl_reply_queue
  import ctrq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req,
  output logic             done,
  output rsp_t             rsp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_SHORT = 2'd2;

  logic [1:0]       state;
  req_t             cmd;
  logic [31:0]      ttl;
  logic [63:0]      last_time;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] rd;
  logic [CNT_W-1:0] wr;
  logic [CNT_W-1:0] dropped;
  logic             pv;
  logic             merged;
  logic             taken;
  logic             bad;
  slot_t            head;
  slot_t            rdata;
  ram_ctl_t         ctl;
  logic [63:0]      expiry_new;
  logic             expired;
  logic             key_hit;
  logic             full;

  assign cfg_ready = (state == S_IDLE);
  assign busy = (state != S_IDLE);
  assign expiry_new = cmd.now_ms + {32'd0, ttl};
  assign expired = rdata.expiry <= cmd.now_ms;
  assign key_hit = (rdata.target == cmd.target) && (rdata.request == cmd.request_code);
  assign full = (wr == CNT_W'(CAPACITY));

  ctrq_slot_ram u_ram (.clk(clk), .ctl(ctl), .rdata(rdata));

  // Read next slot, write back survivor (merged if keyed, not a taken head), append at end.
  always_comb begin
    ctl.raddr = rd[IDX_W-1:0];
    ctl.we = 1'b0;
    ctl.waddr = wr[IDX_W-1:0];
    ctl.wdata = rdata;
    if (state == S_SWEEP) begin
      if (pv) begin
        if (!expired && !(cmd.func == FUNC_TAKE && !taken)) begin
          ctl.we = 1'b1;
          if (cmd.func == FUNC_ENQ && !merged && key_hit) begin
            ctl.wdata.payload = cmd.payload;
            ctl.wdata.expiry = expiry_new;
            if (rdata.repeats != '1) begin
              ctl.wdata.repeats = rdata.repeats + 32'd1;
            end
          end
        end
      end else if (rd == fill && cmd.func == FUNC_ENQ && !merged && !full) begin
        ctl.we = 1'b1;
        ctl.wdata.target = cmd.target;
        ctl.wdata.request = cmd.request_code;
        ctl.wdata.payload = cmd.payload;
        ctl.wdata.expiry = expiry_new;
        ctl.wdata.repeats = 32'd1;
      end
    end
  end

  always_comb begin
    bad = 1'b0;
    if (req.func != FUNC_NOP) begin
      bad = (req.now_ms < last_time) ||
            (req.func == FUNC_ENQ && req.now_ms > ~64'd0 - {32'd0, ttl});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ttl <= 32'd1000;
      last_time <= '0;
      fill <= '0;
      done <= 1'b0;
    end else begin
      // Strobe done for one cycle after a short operation or a finished sweep.
      done <= (state == S_SHORT) || (state == S_SWEEP && !pv && rd == fill);
      if (cfg_valid && cfg_ready) begin
        ttl <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd <= req;
            rd <= '0;
            wr <= '0;
            dropped <= '0;
            pv <= 1'b0;
            merged <= 1'b0;
            taken <= 1'b0;
            rsp <= '0;
            if (req.func == FUNC_NOP || bad) begin
              state <= S_SHORT;
            end else begin
              state <= S_SWEEP;
            end
          end
        end
        S_SHORT: begin
          // Only the unused selector or a rejected time lands here.
          rsp.status <= (cmd.func == FUNC_NOP) ? ST_OK : ST_BAD_TIME;
          rsp.occupancy <= fill;
          state <= S_IDLE;
        end
        S_SWEEP: begin
          // Advance the read pointer; data returns the next cycle.
          pv <= (rd != fill);
          if (rd != fill) begin
            rd <= rd + CNT_W'(1);
          end
          if (pv) begin
            if (expired) begin
              dropped <= dropped + CNT_W'(1);
            end else if (cmd.func == FUNC_TAKE && !taken) begin
              taken <= 1'b1;
              head <= rdata;
            end else begin
              wr <= wr + CNT_W'(1);
              if (cmd.func == FUNC_ENQ && key_hit) begin
                merged <= 1'b1;
              end
            end
          end else if (rd == fill) begin
            // Sweep finished: close out the operation.
            state <= S_IDLE;
            if (cmd.func == FUNC_ENQ && !merged && full) begin
              // Nothing dropped, so the slots are unchanged; hold last time.
              rsp.status <= ST_FULL_EMPTY;
              rsp.occupancy <= wr;
            end else if (cmd.func == FUNC_ENQ && !merged) begin
              rsp.purged <= dropped;
              rsp.occupancy <= wr + CNT_W'(1);
              fill <= wr + CNT_W'(1);
              last_time <= cmd.now_ms;
            end else begin
              rsp.purged <= dropped;
              rsp.occupancy <= wr;
              fill <= wr;
              last_time <= cmd.now_ms;
              if (cmd.func == FUNC_ENQ) begin
                rsp.coalesced <= merged;
              end else if (cmd.func == FUNC_TAKE) begin
                if (!taken) begin
                  rsp.status <= ST_FULL_EMPTY;
                end else begin
                  rsp.taken_target <= head.target;
                  rsp.taken_request <= head.request;
                  rsp.taken_payload <= head.payload;
                  rsp.taken_expiry <= head.expiry;
                  rsp.taken_repeats <= head.repeats;
                end
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(CAPACITY)) else $error("fill level beyond capacity");
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP |-> wr <= rd) else $error("compaction write passed read");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("result while busy");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP |=> $stable(ttl)) else $error("ttl changed during sweep");
`endif
endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking testbench for coalescing_ttl_reply_queue: a directed table, then random traffic.
// Each result is checked against an in-bench queue model or a typed row. Depends on ctrq_pkg.
`default_nettype none
module tb;
  import ctrq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 25;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t x;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        done;
  rsp_t        rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // typed expectation that rides along with the command on the bus
  logic        typed_on = 1'b0;
  rsp_t        typed_rsp = '0;

  // queue model state
  slot_t       q_slot [CAPACITY];
  int          q_fill;
  logic [63:0] q_last_ms;
  logic [31:0] q_ttl;

  rsp_t        pending_rsp [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          idle_pct = 0;

  coalescing_ttl_reply_queue u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drop expired entries at time now, compacting survivors in order.
  function automatic int sweep_slots(input logic [63:0] now, output slot_t nx [CAPACITY],
                                     output int nf);
    int dropped;
    dropped = 0;
    nf = 0;
    for (int i = 0; i < CAPACITY; i++) nx[i] = '0;
    for (int i = 0; i < q_fill; i++) begin
      if (q_slot[i].expiry <= now) dropped++;
      else begin
        nx[nf] = q_slot[i];
        nf++;
      end
    end
    return dropped;
  endfunction

  function automatic rsp_t queue_op(input req_t r);
    slot_t nx [CAPACITY];
    int    nf;
    int    dropped;
    bit    hit;
    rsp_t  o;
    o = '0;
    dropped = 0;
    if (r.func == FUNC_NOP) begin
    end else if (r.now_ms < q_last_ms) begin
      o.status = ST_BAD_TIME;
    end else if (r.func == FUNC_ENQ) begin
      if (r.now_ms > 64'hFFFF_FFFF_FFFF_FFFF - {32'h0, q_ttl}) begin
        o.status = ST_BAD_TIME;
      end else begin
        dropped = sweep_slots(r.now_ms, nx, nf);
        hit = 1'b0;
        for (int i = 0; i < nf && !hit; i++) begin
          if (nx[i].target == r.target && nx[i].request == r.request_code) begin
            nx[i].payload = r.payload;
            nx[i].expiry = r.now_ms + q_ttl;
            if (nx[i].repeats != 32'hFFFF_FFFF) nx[i].repeats++;
            o.coalesced = 1'b1;
            hit = 1'b1;
          end
        end
        if (!hit && nf >= CAPACITY) begin
          // full: the sweep is thrown away too
          o.status = ST_FULL_EMPTY;
          dropped = 0;
        end else begin
          if (!hit) begin
            nx[nf] = '{r.target, r.request_code, r.payload, r.now_ms + q_ttl, 32'd1};
            nf++;
          end
          q_slot = nx;
          q_fill = nf;
          q_last_ms = r.now_ms;
        end
      end
    end else begin
      dropped = sweep_slots(r.now_ms, nx, nf);
      q_slot = nx;
      q_fill = nf;
      q_last_ms = r.now_ms;
      if (r.func == FUNC_TAKE) begin
        if (q_fill == 0) o.status = ST_FULL_EMPTY;
        else begin
          o.taken_target = q_slot[0].target;
          o.taken_request = q_slot[0].request;
          o.taken_payload = q_slot[0].payload;
          o.taken_expiry = q_slot[0].expiry;
          o.taken_repeats = q_slot[0].repeats;
          for (int i = 0; i + 1 < q_fill; i++) q_slot[i] = q_slot[i + 1];
          q_fill--;
          q_slot[q_fill] = '0;
        end
      end
    end
    o.purged = CNT_W'(dropped);
    o.occupancy = CNT_W'(q_fill);
    return o;
  endfunction

  // Monitor: check results, then predict for the command taken at this edge.
  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (!rst) begin
      if (done) begin
        got = rsp;
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = pending_rsp.pop_front();
          if (got.status !== want.status || got.coalesced !== want.coalesced ||
              got.purged !== want.purged ||
              got.taken_target !== want.taken_target ||
              got.taken_request !== want.taken_request ||
              got.taken_payload !== want.taken_payload ||
              got.taken_expiry !== want.taken_expiry ||
              got.taken_repeats !== want.taken_repeats ||
              got.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected st=%0d co=%0d ex=%0d tgt=%h rq=%h pl=%h %s",
                       want.status, want.coalesced, want.purged, want.taken_target,
                       want.taken_request, want.taken_payload,
                       $sformatf("exp=%h rep=%h occ=%0d", want.taken_expiry,
                                 want.taken_repeats, want.occupancy));
              $display("          actual   st=%0d co=%0d ex=%0d tgt=%h rq=%h pl=%h %s",
                       got.status, got.coalesced, got.purged, got.taken_target,
                       got.taken_request, got.taken_payload,
                       $sformatf("exp=%h rep=%h occ=%0d", got.taken_expiry,
                                 got.taken_repeats, got.occupancy));
            end
          end
        end
      end
      if (start && !busy) begin
        want = queue_op(req);
        pending_rsp.push_back(typed_on ? typed_rsp : want);
      end
      if (cfg_valid && cfg_ready) q_ttl = cfg_data;
    end
  end

  // Watchdog: end the run if no transaction of any kind moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge that accepts the command.
  task automatic issue(input req_t r, input bit typed, input rsp_t x);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    typed_on <= typed;
    typed_rsp <= x;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // Hold until the queue is idle, then write the lifetime register.
  task automatic write_ttl(input logic [31:0] v);
    start <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t mk_req(input logic [1:0] f, input logic [63:0] t,
                                  input logic [47:0] tg, input logic [15:0] rq,
                                  input logic [31:0] pl);
    req_t r;
    r = '{f, t, tg, rq, pl};
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input logic [1:0] st, input bit co, input int occ);
    rsp_t x;
    x = '0;
    x.status = st;
    x.coalesced = co;
    x.occupancy = CNT_W'(occ);
    return x;
  endfunction

  initial begin
    row_t        plan [$];
    row_t        row;
    logic [47:0] key_pool [8];
    logic [63:0] clock_ms;
    logic [63:0] now;
    logic [47:0] tg;
    logic [15:0] rq;
    logic [1:0]  f;
    int          pick;
    int          step_max;
    int          ttl_pick;

    q_fill = 0;
    q_last_ms = '0;
    q_ttl = 32'd1000;
    for (int i = 0; i < CAPACITY; i++) q_slot[i] = '0;
    for (int i = 0; i < 8; i++) key_pool[i] = 48'({$urandom, $urandom});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, lifetime at its reset value of 1000
    row = '{mk_req(FUNC_TAKE, 0, 0, 0, 0), 1, mk_rsp(ST_FULL_EMPTY, 0, 0)};
    plan.push_back(row);
    row = '{mk_req(FUNC_NOP, 0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF), 1,
            mk_rsp(ST_OK, 0, 0)};
    plan.push_back(row);
    row = '{mk_req(FUNC_ENQ, 0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF), 1,
            mk_rsp(ST_OK, 0, 1)};
    plan.push_back(row);
    row = '{mk_req(FUNC_ENQ, 10, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 32'h0), 1,
            mk_rsp(ST_OK, 1, 1)};
    plan.push_back(row);
    row = '{mk_req(FUNC_TAKE, 20, 0, 0, 0), 1, mk_rsp(ST_OK, 0, 0)};
    row.x.taken_target = 48'hFFFF_FFFF_FFFF;
    row.x.taken_request = 16'hFFFF;
    row.x.taken_expiry = 64'd1010;
    row.x.taken_repeats = 32'd2;
    plan.push_back(row);
    row = '{mk_req(FUNC_ENQ, 20, 0, 0, 0), 0, '0};
    plan.push_back(row);
    row = '{mk_req(FUNC_EXPIRE, 19, 0, 0, 0), 1, mk_rsp(ST_BAD_TIME, 0, 1)};
    plan.push_back(row);
    row = '{mk_req(FUNC_ENQ, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 1), 1, mk_rsp(ST_BAD_TIME, 0, 1)};
    plan.push_back(row);
    // fill to capacity with distinct keys, then one more that cannot fit
    for (int i = 1; i <= 16; i++) begin
      row = '{mk_req(FUNC_ENQ, 64'(30 + i), 48'(i), 16'(i), $urandom), 0, '0};
      plan.push_back(row);
    end
    row = '{mk_req(FUNC_EXPIRE, 1020, 0, 0, 0), 0, '0};
    plan.push_back(row);
    row = '{mk_req(FUNC_TAKE, 5000, 0, 0, 0), 0, '0};
    plan.push_back(row);

    idle_pct = 36;
    foreach (plan[i]) issue(plan[i].r, plan[i].typed, plan[i].x);
    typed_on <= 1'b0;
    clock_ms = 64'd5000;

    // random phases: lifetime, time step and sender idling per phase
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_ttl(32'd37); step_max = 12; idle_pct = 36;
        end
        1: begin
          write_ttl(32'd1); step_max = 2; idle_pct = 56;
        end
        2: begin
          write_ttl(32'd0); step_max = 2; idle_pct = 56;
        end
        3: begin
          write_ttl(32'hFFFF_FFFF); step_max = 1 << 26; idle_pct = 0;
        end
        default: begin
          ttl_pick = $urandom_range(1, 5000);
          write_ttl(ttl_pick); step_max = 300; idle_pct = 0;
        end
      endcase
      for (int n = 0; n < (ph == 1 || ph == 2 ? 210 : 420); n++) begin
        pick = $urandom_range(99);
        f = pick < 50 ? FUNC_ENQ : pick < 78 ? FUNC_TAKE : pick < 93 ? FUNC_EXPIRE : FUNC_NOP;
        if ($urandom_range(99) < 5) now = clock_ms - $urandom_range(1, 100);
        else begin
          clock_ms += $urandom_range(0, step_max);
          now = clock_ms;
        end
        pick = $urandom_range(7);
        tg = $urandom_range(3) != 0 ? key_pool[pick] : 48'({$urandom, $urandom});
        rq = $urandom_range(3) != 0 ? 16'(pick[0]) : 16'($urandom);
        issue(mk_req(f, now, tg, rq, $urandom), 0, '0);
      end
    end

    // run time up to the top of the range, where the expiry add would overflow
    write_ttl(32'hFFFF_FFFF);
    clock_ms = 64'hFFFF_FFFE_F000_0000;
    for (int n = 0; n < 16; n++) begin
      clock_ms += 64'd1 << 26;
      issue(mk_req(n[0] ? FUNC_TAKE : FUNC_ENQ, clock_ms, 48'({$urandom, $urandom}),
                   16'($urandom), $urandom), 0, '0);
    end
    issue(mk_req(FUNC_EXPIRE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0), 0, '0);
    issue(mk_req(FUNC_TAKE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0), 0, '0);
    start <= 1'b0;

    wait (pending_rsp.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
